FILE: hw/rtl/mng_pkg.sv
package mng_pkg;

  typedef logic [63:0] word_t;
  typedef word_t [3:0] node_t;

  localparam int unsigned LevelW = 6;
  localparam int unsigned IndexW = 63;
  localparam int unsigned InDataW = 72;
  localparam int unsigned OutDataW = 256;

  localparam word_t GoldenInc = 64'h9e3779b97f4a7c15;
  localparam word_t MixMulA   = 64'hbf58476d1ce4e5b9;
  localparam word_t MixMulB   = 64'h94d049bb133111eb;
  localparam word_t SeedBase  = 64'h6d65726b6c655f32;
  localparam word_t LevelMul  = 64'hd6e8feb86659fd93;
  localparam word_t IndexMul  = 64'ha5a3564e27f8862f;

  // Stages through one mix round
  localparam int unsigned MixDepth = 7;

endpackage

FILE: hw/rtl/mng_mul64.sv
module mng_mul64 (
  input  logic           clk_i,
  input  logic           en_i,
  input  mng_pkg::word_t a_i,
  input  mng_pkg::word_t b_i,
  output mng_pkg::word_t p_o
);
  import mng_pkg::*;

  logic [63:0] ll_full;
  logic [63:0] hl_full;
  logic [63:0] lh_full;
  logic [63:0] ll_q;
  logic [31:0] hl_q;
  logic [31:0] lh_q;
  logic [31:0] cross_sum;
  word_t       p_q;

  // Partial products; only the low half of the cross terms survives mod 2^64
  assign ll_full = a_i[31:0] * b_i[31:0];
  assign hl_full = a_i[63:32] * b_i[31:0];
  assign lh_full = a_i[31:0] * b_i[63:32];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= ll_full;
      hl_q <= hl_full[31:0];
      lh_q <= lh_full[31:0];
    end
  end

  // Sum the partial products
  assign cross_sum = hl_q + lh_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= ll_q + {cross_sum, 32'd0};
    end
  end

  assign p_o = p_q;

endmodule

FILE: hw/rtl/mng_seed.sv
module mng_seed (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [mng_pkg::LevelW-1:0]   level_i,
  input  logic [mng_pkg::IndexW-1:0]   node_index_i,
  output logic                         valid_o,
  output mng_pkg::word_t               seed_o
);
  import mng_pkg::*;

  logic [2:0] vld_q;
  word_t      lvl_full;
  word_t      lvl1_q;
  word_t      lvl2_q;
  word_t      idx_prod;
  word_t      seed_q;

  // Index product over two stages
  mng_mul64 u_idx_mul (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   ({1'b0, node_index_i}),
    .b_i   (IndexMul),
    .p_o   (idx_prod)
  );

  // Level product is narrow, one stage, then held to line up
  assign lvl_full = {{(64-LevelW){1'b0}}, level_i} * LevelMul;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lvl1_q <= lvl_full;
      lvl2_q <= lvl1_q;
      seed_q <= SeedBase ^ lvl2_q ^ idx_prod;
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  assign valid_o = vld_q[2];
  assign seed_o  = seed_q;

endmodule

FILE: hw/rtl/mng_mix.sv
module mng_mix (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic [1:0]     k_i,
  input  logic           valid_i,
  input  mng_pkg::word_t x_i,
  input  mng_pkg::node_t words_i,
  output logic           valid_o,
  output mng_pkg::word_t x_o,
  output mng_pkg::node_t words_o
);
  import mng_pkg::*;

  logic [MixDepth-1:0] vld_q;
  node_t               wds_q [MixDepth];
  word_t               z;
  word_t               a_q;
  word_t               p1;
  word_t               c_q;
  word_t               p2;
  word_t               e_q;
  node_t               wds_out;

  // Add round offset and golden increment, first xorshift
  assign z = x_i + {62'd0, k_i} + GoldenInc;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= z ^ (z >> 30);
    end
  end

  mng_mul64 u_mul_a (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (a_q),
    .b_i   (MixMulA),
    .p_o   (p1)
  );

  // Second xorshift
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= p1 ^ (p1 >> 27);
    end
  end

  mng_mul64 u_mul_b (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (c_q),
    .b_i   (MixMulB),
    .p_o   (p2)
  );

  // Final xorshift gives this round's word
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q <= p2 ^ (p2 >> 31);
    end
  end

  // Carry the words of earlier rounds alongside
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wds_q[0] <= words_i;
      for (int i = 1; i < MixDepth; i++) begin
        wds_q[i] <= wds_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[MixDepth-2:0], valid_i};
    end
  end

  // Drop this round's word into its slot
  always_comb begin
    wds_out      = wds_q[MixDepth-1];
    wds_out[k_i] = e_q;
  end

  assign valid_o = vld_q[MixDepth-1];
  assign x_o     = e_q;
  assign words_o = wds_out;

endmodule

FILE: hw/rtl/merkle_node_generator_unit.sv
// Merkle node generator: one synthetic 32-byte node per item.
// Slave side: s_axis_tdata_i carries level (6 bits) and node index
// (63 bits); the item is taken when tvalid and tready are both high.
// Master side: m_axis_tdata_o carries the four 64-bit node words,
// word0 (node bytes 0 to 7, little-endian) in the lowest bits.
// Path from acceptance to tvalid on the master side: the seed (index
// multiply and combine), then the four chained mix rounds, each round
// holding two 64-bit constant multiplies split into 32-bit partial
// products.
// Throughput: one item per cycle while the receiver takes items.
// Stall: the whole pipeline holds while a result waits and tready is
// low; tready on the slave side follows, so nothing is lost or repeated.
// The last mix register is the output register, so an item is still
// accepted in a cycle in which the waiting result is taken.
// Reset: clears all valid bits; the block starts empty and ready.
module merkle_node_generator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // level [5:0], node index [68:6], zero [71:69]
  input  logic [mng_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // word0 [63:0], word1 [127:64], word2 [191:128], word3 [255:192]
  output logic [mng_pkg::OutDataW-1:0]   m_axis_tdata
);
  import mng_pkg::*;

  logic  adv;
  logic  seed_vld;
  word_t seed;
  logic  vld   [5];
  word_t run   [5];
  node_t words [5];

  // Advance everything while the output is empty or being taken
  assign adv           = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = adv;

  mng_seed u_seed (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (adv),
    .valid_i      (s_axis_tvalid),
    .level_i      (s_axis_tdata[LevelW-1:0]),
    .node_index_i (s_axis_tdata[LevelW+IndexW-1:LevelW]),
    .valid_o      (seed_vld),
    .seed_o       (seed)
  );

  assign vld[0]   = seed_vld;
  assign run[0]   = seed;
  assign words[0] = '0;

  // Four chained mix rounds
  for (genvar g = 0; g < 4; g++) begin : g_round
    mng_mix u_mix (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .k_i     (2'(g)),
      .valid_i (vld[g]),
      .x_i     (run[g]),
      .words_i (words[g]),
      .valid_o (vld[g+1]),
      .x_o     (run[g+1]),
      .words_o (words[g+1])
    );
  end

  assign m_axis_tvalid = vld[4];
  assign m_axis_tdata  = words[4];

endmodule

FILE: test/merkle_node_checker.sv
module merkle_node_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  // level [5:0], node index [68:6], zero [71:69]
  input  logic [mng_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // word0 [63:0], word1 [127:64], word2 [191:128], word3 [255:192]
  input  logic [mng_pkg::OutDataW-1:0]  m_axis_tdata,
  output int unsigned                   fault_count_o,
  output int unsigned                   nodes_in_flight_o
);

  import mng_pkg::word_t;
  import mng_pkg::node_t;

  // Hash constants, kept apart from the design's own copy
  localparam logic [63:0] StepInc  = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] StirA    = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] StirB    = 64'h94d049bb133111eb;
  localparam logic [63:0] NodeSalt = 64'h6d65726b6c655f32;
  localparam logic [63:0] LevelK   = 64'hd6e8feb86659fd93;
  localparam logic [63:0] IndexK   = 64'ha5a3564e27f8862f;

  localparam int unsigned ReportMax = 10;

  node_t expected_nodes[$];

  function automatic word_t stir_word(input word_t x);
    word_t z;
    z = x + StepInc;
    z = (z ^ (z >> 30)) * StirA;
    z = (z ^ (z >> 27)) * StirB;
    return z ^ (z >> 31);
  endfunction

  // Seed from level and index, then four chained stirs, one per word
  function automatic node_t derive_node(input logic [5:0] lvl, input logic [62:0] idx);
    word_t chain;
    node_t node;
    chain = NodeSalt ^ ({58'd0, lvl} * LevelK) ^ ({1'b0, idx} * IndexK);
    for (int k = 0; k < 4; k++) begin
      chain = stir_word(chain + 64'(k));
      node[k] = chain;
    end
    return node;
  endfunction

  // Predict on each accepted request, compare on each accepted node
  always @(posedge clk_i) begin
    node_t want;
    node_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_nodes = {expected_nodes,
                          derive_node(s_axis_tdata[5:0], s_axis_tdata[68:6])};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = node_t'(m_axis_tdata);
        if (expected_nodes.size() == 0) begin
          if (fault_count_o < ReportMax) begin
            $display("node out with no request pending: %h", got);
          end
          fault_count_o++;
        end else begin
          want = expected_nodes.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (got[k] !== want[k]) begin
              if (fault_count_o < ReportMax) begin
                $display("word%0d mismatch: expected %h, got %h", k, want[k], got[k]);
              end
              fault_count_o++;
            end
          end
        end
      end
    end
    nodes_in_flight_o = $unsigned(expected_nodes.size());
  end

endmodule

FILE: test/merkle_node_generator_unit_test.sv
module merkle_node_generator_unit_test;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned PhaseItems = 317;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [mng_pkg::InDataW-1:0]   s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [mng_pkg::OutDataW-1:0]  m_axis_tdata;

  int unsigned fault_count;
  int unsigned nodes_in_flight;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;

  merkle_node_generator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  merkle_node_checker node_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .fault_count_o     (fault_count),
    .nodes_in_flight_o (nodes_in_flight)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the node output at random
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL merkle_node_generator_unit");
      $finish;
    end
  end

  // Offer one request, idling beforehand at random; returns at a falling edge
  task automatic request_node(input logic [5:0] lvl, input logic [62:0] idx);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, idx, lvl};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Mostly indices inside their level, the rest anywhere in 63 bits
  task automatic random_requests(input int unsigned count);
    logic [5:0]  lvl;
    logic [63:0] raw;
    for (int unsigned n = 0; n < count; n++) begin
      lvl = 6'($urandom_range(63));
      raw = {$urandom, $urandom};
      if ($urandom_range(99) < 70) begin
        raw = raw & ((64'd1 << lvl) - 64'd1);
      end
      request_node(lvl, raw[62:0]);
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Extremes, root level and indices beyond their level
    request_node(6'd0,  63'd0);
    request_node(6'd63, {63{1'b1}});
    request_node(6'd0,  {63{1'b1}});
    request_node(6'd63, 63'd0);
    request_node(6'd1,  63'd1);
    request_node(6'd3,  63'd100);
    request_node(6'd42, {{31{2'b10}}, 1'b1});
    request_node(6'd15, {{31{2'b01}}, 1'b0});
    request_node(6'd62, (63'd1 << 62) - 63'd1);
    request_node(6'd63, 63'd1 << 62);
    request_node(6'd10, 63'd1023);
    request_node(6'd10, 63'd1024);
    request_node(6'd32, 63'hffff_ffff);

    src_idle_pct  = 29;
    sink_idle_pct = 86;
    random_requests(PhaseItems);
    src_idle_pct  = 86;
    sink_idle_pct = 29;
    random_requests(PhaseItems);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    random_requests(PhaseItems);

    s_axis_tvalid <= 1'b0;
    while (nodes_in_flight != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fault_count == 0) begin
      $display("PASS merkle_node_generator_unit");
    end else begin
      $display("FAIL merkle_node_generator_unit");
    end
    $finish;
  end

endmodule
